// ----- rtl/lrs_pkg.sv -----
// Package for the keyed rate sampler: beat, entry and control types,
// register codes and the shared window test.
// No dependencies.
package lrs_pkg;

    localparam int WAYS   = 256;
    localparam int WAY_W  = 8;
    localparam int CNT_W  = 9;
    localparam int KEY_W  = 64;
    localparam int TIME_W = 40;
    localparam int TOT_W  = 32;
    localparam int HITS_W = 16;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    typedef struct packed {
        logic [KEY_W-1:0]  key_hash;
        logic [TIME_W-1:0] timestamp_ms;
    } evt_t;

    typedef struct packed {
        logic [1:0]       capture_mode;
        logic [TOT_W-1:0] total_seen;
    } res_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TOT_W-1:0]  total;
        logic [TIME_W-1:0] window_start;
        logic [HITS_W-1:0] win_hits;
        logic [TIME_W-1:0] last_full;
    } entry_data_t;

    typedef struct packed {
        logic        valid;
        entry_data_t data;
    } entry_t;

    typedef struct packed {
        logic             upd;
        logic             hit;
        logic [WAY_W-1:0] hit_idx;
        logic             kill;
        logic [CNT_W-1:0] kill_idx;
    } cell_ctl_t;

    typedef struct packed {
        logic [31:0] window_length_ms;
        logic [15:0] full_limit;
        logic [15:0] reduced_limit;
        logic [31:0] resample_period_ms;
        logic [8:0]  stripe_capacity;
    } cfg_t;

    typedef enum logic [IDX_W-1:0] {
        REG_WINDOW_LEN  = 3'd0,
        REG_FULL_LIMIT  = 3'd1,
        REG_REDUCED_LIM = 3'd2,
        REG_RESAMPLE    = 3'd3,
        REG_CAPACITY    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_FULL       = 2'd0,
        MODE_REDUCED    = 2'd1,
        MODE_COUNT_ONLY = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // True when the stamp is unset or at least period ms have gone by
    function automatic logic elapsed(input logic [TIME_W-1:0] stamp,
                                     input logic [TIME_W-1:0] now,
                                     input logic [31:0]       period);
        logic [TIME_W-1:0] diff;
        diff = now - stamp;
        if (stamp == '0)
            return 1'b1;
        else if (now < stamp)
            return 1'b0;
        else
            return diff >= {{(TIME_W-32){1'b0}}, period};
    endfunction

endpackage

// ----- rtl/lrs_cell.sv -----
// One way of the recency-ordered chain: stores an entry, compares its key
// and takes its neighbor's entry on a shift. Depends on lrs_pkg.
module lrs_cell
    import lrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [WAY_W-1:0] way_idx,
    input  cell_ctl_t        ctl,
    input  entry_t           head,
    input  entry_t           prev,
    input  logic [KEY_W-1:0] cmp_key,
    output entry_t           entry,
    output logic             match
);

    logic        valid_reg;
    logic        valid_next;
    entry_data_t data_reg;
    logic        take;
    entry_t      src;

    // Shift on a miss, or up to the hit way on a hit; way 0 takes the head
    always_comb
    begin
        take = ctl.upd && (!ctl.hit || (way_idx <= ctl.hit_idx));
        src  = (way_idx == '0) ? head : prev;
        valid_next = valid_reg;
        if (take)
            valid_next = src.valid;
        if (ctl.upd && ctl.kill && ({1'b0, way_idx} == ctl.kill_idx))
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            data_reg <= src.data;
    end

    assign entry.valid = valid_reg;
    assign entry.data  = data_reg;
    assign match       = valid_reg && (data_reg.key == cmp_key);

endmodule

// ----- rtl/lrs_update.sv -----
// Entry update and capture decision for the selected way.
// Depends on lrs_pkg.
module lrs_update
    import lrs_pkg::*;
(
    input  logic              hit,
    input  entry_data_t       hit_data,
    input  logic [KEY_W-1:0]  key,
    input  logic [TIME_W-1:0] now,
    input  cfg_t              cfg,
    output entry_data_t       new_data,
    output mode_t             mode
);

    entry_data_t base;
    entry_data_t upd;

    always_comb
    begin
        // Start from the hit entry, or a zeroed one on a miss
        if (hit)
            base = hit_data;
        else
            base = '0;
        base.key = key;
        upd = base;

        // Saturating total
        if (upd.total != '1)
            upd.total = upd.total + 1'b1;

        // Roll the window when unset or expired
        if (elapsed(upd.window_start, now, cfg.window_length_ms))
        begin
            upd.window_start = now;
            upd.win_hits     = '0;
        end
        if (upd.win_hits != '1)
            upd.win_hits = upd.win_hits + 1'b1;

        // Decide the capture mode
        if (elapsed(upd.last_full, now, cfg.resample_period_ms) ||
            (upd.win_hits <= cfg.full_limit))
        begin
            upd.last_full = now;
            mode = MODE_FULL;
        end
        else if (upd.win_hits <= cfg.reduced_limit)
            mode = MODE_REDUCED;
        else
            mode = MODE_COUNT_ONLY;

        new_data = upd;
    end

endmodule

// ----- rtl/lru_keyed_rate_sampler_top.sv -----
// Top level of the keyed rate sampler: config registers, sequencer, way chain
// and result register. Depends on lrs_pkg, lrs_cell and lrs_update.
//
//  channel | ports                          | beat
//  --------+--------------------------------+-----------------------------
//  event   | evt_valid, evt_stall, evt      | key_hash, timestamp_ms
//  result  | res_valid, res_stall, res      | capture_mode, total_seen
//  config  | cfg_wr_en, cfg_index, cfg_wr_data | one register write
//
// An event passes through ST_CMP, which compares the key in all ways and registers
// the matched entry, then ST_UPD, which updates it and shifts the recency chain.
// A new event is taken in the update cycle, while the last one is still being written.
// A stalled result holds the update cycle until the result register frees.
// Reset clears all way valid bits at once; no clearing pass is needed.
module lru_keyed_rate_sampler_top
    import lrs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             evt_valid,
    output logic             evt_stall,
    input  evt_t             evt,
    output logic             res_valid,
    input  logic             res_stall,
    output res_t             res,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    cfg_t             cfg_reg;
    state_t           state_reg, state_next;
    evt_t             evt_reg;
    logic             hit_reg;
    logic [WAY_W-1:0] hit_idx_reg;
    entry_data_t      hit_data_reg;
    logic [CNT_W-1:0] count_reg;
    logic             res_valid_reg;
    res_t             res_reg;

    logic             out_free;
    logic             accept;
    logic             upd;
    logic [CNT_W-1:0] cap_eff;
    cell_ctl_t        ctl;
    entry_t           head;
    entry_t           cells [WAYS];
    logic [WAYS-1:0]  match_vec;
    logic [WAYS-1:0]  valid_vec;
    logic             hit_any;
    logic [WAY_W-1:0] hit_idx_any;
    entry_data_t      hit_data_any;
    entry_data_t      new_data;
    mode_t            mode;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length_ms   <= 32'd60000;
            cfg_reg.full_limit         <= 16'd10;
            cfg_reg.reduced_limit      <= 16'd50;
            cfg_reg.resample_period_ms <= 32'd300000;
            cfg_reg.stripe_capacity    <= 9'd256;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WINDOW_LEN:  cfg_reg.window_length_ms   <= cfg_wr_data;
                REG_FULL_LIMIT:  cfg_reg.full_limit         <= cfg_wr_data[15:0];
                REG_REDUCED_LIM: cfg_reg.reduced_limit      <= cfg_wr_data[15:0];
                REG_RESAMPLE:    cfg_reg.resample_period_ms <= cfg_wr_data;
                REG_CAPACITY:    cfg_reg.stripe_capacity    <= cfg_wr_data[8:0];
                default:         ;
            endcase
        end
    end

    // Handshake and sequencer
    assign out_free = !res_valid_reg || !res_stall;
    assign upd      = (state_reg == ST_UPD) && out_free;

    always_comb
    begin
        state_next = state_reg;
        evt_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                evt_stall = 1'b0;
                if (evt_valid)
                    state_next = ST_CMP;
            end
            ST_CMP:
                state_next = ST_UPD;
            ST_UPD:
            begin
                if (out_free)
                begin
                    evt_stall  = 1'b0;
                    state_next = evt_valid ? ST_CMP : ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign accept = evt_valid && !evt_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            evt_reg <= evt;
    end

    // Collapse the one-hot match into the hit way and its entry
    always_comb
    begin
        hit_any      = 1'b0;
        hit_idx_any  = '0;
        hit_data_any = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (match_vec[i])
            begin
                hit_any      = 1'b1;
                hit_idx_any  = hit_idx_any | WAY_W'(i);
                hit_data_any = hit_data_any | cells[i].data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMP)
        begin
            hit_reg      <= hit_any;
            hit_idx_reg  <= hit_idx_any;
            hit_data_reg <= hit_data_any;
        end
    end

    // Updated entry and decision
    lrs_update u_update (
        .hit      (hit_reg),
        .hit_data (hit_data_reg),
        .key      (evt_reg.key_hash),
        .now      (evt_reg.timestamp_ms),
        .cfg      (cfg_reg),
        .new_data (new_data),
        .mode     (mode)
    );

    // Chain control: evict the last valid way when the stripe is full
    always_comb
    begin
        if (cfg_reg.stripe_capacity == '0)
            cap_eff = CNT_W'(1);
        else if (cfg_reg.stripe_capacity > CNT_W'(WAYS))
            cap_eff = CNT_W'(WAYS);
        else
            cap_eff = cfg_reg.stripe_capacity;
        ctl.upd      = upd;
        ctl.hit      = hit_reg;
        ctl.hit_idx  = hit_idx_reg;
        ctl.kill     = !hit_reg && (count_reg >= cap_eff) && (count_reg != '0);
        ctl.kill_idx = count_reg;
        head.valid   = 1'b1;
        head.data    = new_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (upd && !ctl.hit && !ctl.kill)
            count_reg <= count_reg + 1'b1;
    end

    // Way chain, most recent at way 0
    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        lrs_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .way_idx (WAY_W'(g)),
            .ctl     (ctl),
            .head    (head),
            .prev    ((g == 0) ? head : cells[(g == 0) ? 0 : g-1]),
            .cmp_key (evt_reg.key_hash),
            .entry   (cells[g]),
            .match   (match_vec[g])
        );
        assign valid_vec[g] = cells[g].valid;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (upd)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            res_reg.capture_mode <= mode;
            res_reg.total_seen   <= new_data.total;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Checks
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("valid way count differs from fill count");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
        else $error("key matched in more than one way");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("result raised outside the update cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WAYS))
        else $error("fill count above way count");

endmodule
